### sv/isb_pkg.sv
// shared constants, types and command/status structs of the interpolating sample buffer
package isb_pkg;

    // sizing of the store and the interpolation
    localparam int MAX_FRAMES    = 1024;
    localparam int FRACTION_BITS = 16;

    // fixed field widths
    localparam int ACTION_W      = 2;
    localparam int INDEX_W       = 10;
    localparam int FRAC_FIELD_W  = 16;
    localparam int SAMPLE_W      = 16;
    localparam int CHANNELS_W    = 2;
    localparam int FRAMES_W      = 11;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 11;

    // derived widths
    localparam int ROW_W     = $clog2(MAX_FRAMES);
    localparam int FRAC_USED = (FRACTION_BITS < FRAC_FIELD_W) ? FRACTION_BITS : FRAC_FIELD_W;
    localparam int PROD_W    = FRAC_USED + SAMPLE_W + 2;
    localparam int ACC_W     = FRACTION_BITS + SAMPLE_W + 3;
    localparam int LIM_MIN_W = $clog2(MAX_FRAMES + 1);
    localparam int LIM_W     = (FRAMES_W > LIM_MIN_W) ? FRAMES_W : LIM_MIN_W;

    // register reset values
    localparam logic [CHANNELS_W-1:0] CHANNELS_RESET = 2'd1;
    localparam logic [FRAMES_W-1:0]   FRAMES_RESET   = 11'd1024;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 1'd1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_MIX   = 2'd2,
        ACT_CLEAR = 2'd3
    } isb_action_t;

    typedef enum logic [3:0] {
        ST_INIT_SWEEP,
        ST_IDLE,
        ST_DISPATCH,
        ST_SWEEP,
        ST_STORE,
        ST_RD_B,
        ST_CAP_B,
        ST_MUL_L,
        ST_MUL_R,
        ST_FIN_R,
        ST_DONE
    } isb_state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic rd_second;
        logic cap_first;
        logic cap_second;
        logic store;
        logic sweep;
        logic mul_en;
        logic mul_right;
        logic fin_en;
        logic fin_right;
        logic out_load;
    } isb_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        isb_action_t action;
        logic        err;
        logic        stereo;
        logic        sweep_last;
        logic        out_free;
    } isb_stat_t;

endpackage

### sv/isb_in_if.sv
// input channel: one action item per beat
interface isb_in_if
    import isb_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic [INDEX_W-1:0]         frame_index;
    logic [FRAC_FIELD_W-1:0]    position_fraction;
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;

    modport source (
        output valid, action, frame_index, position_fraction, sample_left, sample_right,
        input  ready
    );
    modport sink (
        input  valid, action, frame_index, position_fraction, sample_left, sample_right,
        output ready
    );
endinterface

### sv/isb_out_if.sv
// output channel: one result per beat
interface isb_out_if
    import isb_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic                       status;

    modport source (
        output valid, out_left, out_right, status,
        input  ready
    );
    modport sink (
        input  valid, out_left, out_right, status,
        output ready
    );
endinterface

### sv/interpolating_sample_buffer.sv
// top level of the interpolating sample buffer: controller plus datapath
//
//   channel      dir   handshake      payload
//   sample_in    in    valid/ready    action, frame_index, position_fraction,
//                                     sample_left, sample_right
//   result_out   out   valid/ready    out_left, out_right, status
//   config       in    cfg_we         cfg_index, cfg_data
//
// a clear zeroes one store row of both banks per cycle; after each result the controller
// returns to idle before the next beat is taken
// stereo reads use two registered store reads, mono reads one; one multiplier is shared
// after reset a clearing pass over every store row runs before the first beat is taken
// one item at a time; a result held in the output register does not block
// the next input beat, only the finishing of the following item
module interpolating_sample_buffer
    import isb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    isb_in_if.sink                sample_in,
    isb_out_if.source             result_out,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    isb_cmd_t  cmd;
    isb_stat_t stat;

    // sequencer
    isb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_in.valid),
        .in_ready (sample_in.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // store and arithmetic
    isb_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .action            (sample_in.action),
        .frame_index       (sample_in.frame_index),
        .position_fraction (sample_in.position_fraction),
        .sample_left       (sample_in.sample_left),
        .sample_right      (sample_in.sample_right),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .out_valid         (result_out.valid),
        .out_ready         (result_out.ready),
        .out_left          (result_out.out_left),
        .out_right         (result_out.out_right),
        .out_status        (result_out.status)
    );

endmodule

### sv/isb_ctrl.sv
// controller state machine: sequences sweeps, stores and interpolated reads
module isb_ctrl
    import isb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  isb_stat_t stat,
    output isb_cmd_t  cmd
);

    isb_state_t state_reg;
    isb_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_INIT_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                // first read row is addressed during this cycle
                if (stat.err)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    case (stat.action)
                        ACT_CLEAR: state_next = ST_SWEEP;
                        ACT_WRITE: state_next = ST_STORE;
                        ACT_MIX:   state_next = ST_STORE;
                        ACT_READ:  state_next = ST_RD_B;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = ST_DONE;
            end
            ST_RD_B:
            begin
                cmd.cap_first = 1'b1;
                cmd.rd_second = 1'b1;
                state_next    = stat.stereo ? ST_CAP_B : ST_MUL_L;
            end
            ST_CAP_B:
            begin
                cmd.cap_second = 1'b1;
                state_next     = ST_MUL_L;
            end
            ST_MUL_L:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_MUL_R;
            end
            ST_MUL_R:
            begin
                cmd.fin_en = 1'b1;
                if (stat.stereo)
                begin
                    cmd.mul_en    = 1'b1;
                    cmd.mul_right = 1'b1;
                    state_next    = ST_FIN_R;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FIN_R:
            begin
                cmd.fin_en    = 1'b1;
                cmd.fin_right = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/isb_datapath.sv
// datapath: config registers, two-bank sample store, lerp unit and result register
module isb_datapath
    import isb_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  isb_cmd_t                   cmd,
    output isb_stat_t                  stat,
    // item fields
    input  logic [ACTION_W-1:0]        action,
    input  logic [INDEX_W-1:0]         frame_index,
    input  logic [FRAC_FIELD_W-1:0]    position_fraction,
    input  logic signed [SAMPLE_W-1:0] sample_left,
    input  logic signed [SAMPLE_W-1:0] sample_right,
    // config writes
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    // result
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] out_left,
    output logic signed [SAMPLE_W-1:0] out_right,
    output logic                       out_status
);

    // config registers
    logic [CHANNELS_W-1:0] channels_reg;
    logic [FRAMES_W-1:0]   frames_reg;

    // item registers
    isb_action_t                action_reg;
    logic [INDEX_W-1:0]         idx_reg;
    logic [FRAC_USED-1:0]       frac_reg;
    logic signed [SAMPLE_W-1:0] sl_reg;
    logic signed [SAMPLE_W-1:0] sr_reg;

    // store banks: even mono entries or left samples in bank 0, the rest in bank 1
    logic [SAMPLE_W-1:0] bank0_mem [MAX_FRAMES];
    logic [SAMPLE_W-1:0] bank1_mem [MAX_FRAMES];
    logic [SAMPLE_W-1:0] q0_reg;
    logic [SAMPLE_W-1:0] q1_reg;

    // operands, product and results
    logic signed [SAMPLE_W-1:0] a_l_reg;
    logic signed [SAMPLE_W-1:0] a_r_reg;
    logic signed [SAMPLE_W-1:0] b_l_reg;
    logic signed [SAMPLE_W-1:0] b_r_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SAMPLE_W-1:0] base_reg;
    logic signed [SAMPLE_W-1:0] res_l_reg;
    logic signed [SAMPLE_W-1:0] res_r_reg;

    // sweep and output control
    logic [ROW_W-1:0] sweep_cnt_reg;
    logic [ROW_W-1:0] sweep_cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic signed [SAMPLE_W-1:0] out_left_reg;
    logic signed [SAMPLE_W-1:0] out_right_reg;
    logic                       out_status_reg;

    logic             stereo;
    logic             frac_nz;
    logic             err;
    logic [LIM_W-1:0] lim;
    logic [LIM_W-1:0] frames_ext;
    logic [LIM_W-1:0] idx_ext;
    logic [LIM_W-1:0] idx_p1_ext;
    logic [ROW_W:0]   idx_row_p1;
    logic [ROW_W-1:0] raddr0;
    logic [ROW_W-1:0] raddr1;
    logic [ROW_W-1:0] waddr;
    logic             we0;
    logic             we1;
    logic [SAMPLE_W-1:0] wdata0;
    logic [SAMPLE_W-1:0] wdata1;
    logic             is_mix;
    logic             sweep_last;

    logic signed [SAMPLE_W-1:0] mul_a;
    logic signed [SAMPLE_W-1:0] mul_b;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [PROD_W-1:0]   prod;
    logic signed [ACC_W-1:0]    base_ext;
    logic signed [ACC_W-1:0]    prod_ext;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    acc_sh;
    logic                       round_up;
    logic signed [SAMPLE_W-1:0] lerp_val;

    // config register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channels_reg <= CHANNELS_RESET;
            frames_reg   <= FRAMES_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CHANNEL_COUNT: channels_reg <= cfg_data[CHANNELS_W-1:0];
                CFG_FRAMES_IN_USE: frames_reg   <= cfg_data[FRAMES_W-1:0];
                default:           channels_reg <= channels_reg;
            endcase
        end
    end

    // item capture on an accepted beat
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= isb_action_t'(action);
            idx_reg    <= frame_index;
            frac_reg   <= position_fraction[FRAC_USED-1:0];
            sl_reg     <= sample_left;
            sr_reg     <= sample_right;
        end
    end

    // range check against the frames in use, capped at the store size
    assign stereo     = channels_reg[1];
    assign frac_nz    = |frac_reg;
    assign frames_ext = LIM_W'(frames_reg);
    assign lim        = (frames_ext > LIM_W'(MAX_FRAMES)) ? LIM_W'(MAX_FRAMES) : frames_ext;
    assign idx_ext    = LIM_W'(idx_reg);
    assign idx_p1_ext = idx_ext + 1'b1;

    always_comb
    begin
        case (action_reg)
            ACT_READ:  err = (idx_ext >= lim) || (frac_nz && (idx_p1_ext >= lim));
            ACT_WRITE: err = (idx_ext >= lim);
            ACT_MIX:   err = (idx_ext >= lim);
            default:   err = 1'b0;
        endcase
    end

    // read addresses: stereo frame i is row i of both banks, mono entry e is row e/2
    assign idx_row_p1 = (ROW_W + 1)'(idx_reg) + 1'b1;

    always_comb
    begin
        if (cmd.rd_second)
        begin
            raddr0 = idx_row_p1[ROW_W-1:0];
            raddr1 = idx_row_p1[ROW_W-1:0];
        end
        else if (stereo)
        begin
            raddr0 = ROW_W'(idx_reg);
            raddr1 = ROW_W'(idx_reg);
        end
        else
        begin
            raddr0 = idx_row_p1[ROW_W:1];
            raddr1 = ROW_W'(idx_reg >> 1);
        end
    end

    // write port: clearing sweep or frame store/mix
    assign is_mix     = (action_reg == ACT_MIX);
    assign sweep_last = (sweep_cnt_reg == ROW_W'(MAX_FRAMES - 1));

    always_comb
    begin
        we0    = 1'b0;
        we1    = 1'b0;
        waddr  = stereo ? ROW_W'(idx_reg) : ROW_W'(idx_reg >> 1);
        wdata0 = (is_mix ? q0_reg : '0) + sl_reg;
        wdata1 = (is_mix ? q1_reg : '0) + (stereo ? sr_reg : sl_reg);
        if (cmd.sweep)
        begin
            we0    = 1'b1;
            we1    = 1'b1;
            waddr  = sweep_cnt_reg;
            wdata0 = '0;
            wdata1 = '0;
        end
        else if (cmd.store)
        begin
            we0 = stereo || !idx_reg[0];
            we1 = stereo || idx_reg[0];
        end
    end

    // bank 0
    always_ff @(posedge clk)
    begin
        if (we0)
        begin
            bank0_mem[waddr] <= wdata0;
        end
        q0_reg <= bank0_mem[raddr0];
    end

    // bank 1
    always_ff @(posedge clk)
    begin
        if (we1)
        begin
            bank1_mem[waddr] <= wdata1;
        end
        q1_reg <= bank1_mem[raddr1];
    end

    // sweep row counter, back at zero after the last row
    assign sweep_cnt_next = sweep_last ? '0 : sweep_cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg <= '0;
        end
        else if (cmd.sweep)
        begin
            sweep_cnt_reg <= sweep_cnt_next;
        end
    end

    // operand capture; the next frame is not used with a zero fraction
    always_ff @(posedge clk)
    begin
        if (cmd.cap_first)
        begin
            if (stereo)
            begin
                a_l_reg <= q0_reg;
                a_r_reg <= q1_reg;
            end
            else
            begin
                a_l_reg <= idx_reg[0] ? q1_reg : q0_reg;
                b_l_reg <= frac_nz ? (idx_reg[0] ? q0_reg : q1_reg) : '0;
            end
        end
        if (cmd.cap_second)
        begin
            b_l_reg <= frac_nz ? q0_reg : '0;
            b_r_reg <= frac_nz ? q1_reg : '0;
        end
    end

    // lerp multiply: frac * (b - a)
    assign mul_a = cmd.mul_right ? a_r_reg : a_l_reg;
    assign mul_b = cmd.mul_right ? b_r_reg : b_l_reg;
    assign diff  = $signed({mul_b[SAMPLE_W-1], mul_b}) - $signed({mul_a[SAMPLE_W-1], mul_a});
    assign prod  = $signed({1'b0, frac_reg}) * diff;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= prod;
            base_reg <= mul_a;
        end
    end

    // lerp finish: a*one + product, divided by one truncating toward zero
    assign base_ext = ACC_W'(base_reg);
    assign prod_ext = ACC_W'(prod_reg);
    assign acc      = (base_ext <<< FRACTION_BITS) + prod_ext;
    assign acc_sh   = acc >>> FRACTION_BITS;
    assign round_up = acc[ACC_W-1] && (acc[FRACTION_BITS-1:0] != '0);
    assign lerp_val = acc_sh[SAMPLE_W-1:0] + SAMPLE_W'(round_up);

    always_ff @(posedge clk)
    begin
        if (cmd.fin_en)
        begin
            if (cmd.fin_right)
            begin
                res_r_reg <= lerp_val;
            end
            else
            begin
                res_l_reg <= lerp_val;
                if (!stereo)
                begin
                    res_r_reg <= lerp_val;
                end
            end
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_left_reg   <= (action_reg == ACT_READ && !err) ? res_l_reg : '0;
            out_right_reg  <= (action_reg == ACT_READ && !err) ? res_r_reg : '0;
            out_status_reg <= err;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_left   = out_left_reg;
    assign out_right  = out_right_reg;
    assign out_status = out_status_reg;

    // status to the controller
    assign stat.action     = action_reg;
    assign stat.err        = err;
    assign stat.stereo     = stereo;
    assign stat.sweep_last = sweep_last;
    assign stat.out_free   = !out_valid_reg || out_ready;

endmodule
